/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define SRT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/srt_pkg.sv */
// types, codes and helpers of the sorted record table
package srt_pkg;

	localparam int ID_W    = 64;
	localparam int SCORE_W = 8;
	localparam int PACK_W  = 4 * SCORE_W;
	localparam int SUM_W   = 10;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_MOD  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [1:0]          op;
		logic [ID_W-1:0]     id;
		logic [PACK_W-1:0]   scores;
		logic [1:0]          slot;
		logic [SCORE_W-1:0]  nscore;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [ID_W-1:0]     id;
		logic [PACK_W-1:0]   scores;
		logic [SUM_W-1:0]    total;
		logic                last;
	} res_t;

	function automatic logic [SUM_W-1:0] packed_sum(input logic [PACK_W-1:0] p);
		return SUM_W'(p[7:0]) + SUM_W'(p[15:8]) + SUM_W'(p[23:16]) + SUM_W'(p[31:24]);
	endfunction

endpackage

/* hw/rtl/srt_front.sv */
// command intake: drops unused ops and queues transactions for the engine
module srt_front import srt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd_in,
	output logic busy,
	output logic q_valid,
	output cmd_t q_cmd,
	input  logic pop
);

	cmd_t       buf_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy && (cmd_in.op != OP_NONE);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* hw/rtl/srt_back.sv */
// execution engine: record stores, id search, insertion sort and readout
module srt_back import srt_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int ID_BITS  = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic pop,
	output logic done,
	output res_t res
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SB_W  = IDX_W + SUM_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_M_ORD = 4'd1;
	localparam logic [3:0] S_M_ID  = 4'd2;
	localparam logic [3:0] S_M_CMP = 4'd3;
	localparam logic [3:0] S_L_ORD = 4'd4;
	localparam logic [3:0] S_L_SUM = 4'd5;
	localparam logic [3:0] S_L_WR  = 4'd6;
	localparam logic [3:0] S_K_RD  = 4'd7;
	localparam logic [3:0] S_K_LD  = 4'd8;
	localparam logic [3:0] S_J_RD  = 4'd9;
	localparam logic [3:0] S_J_CMP = 4'd10;
	localparam logic [3:0] S_PUT   = 4'd11;
	localparam logic [3:0] S_E_ORD = 4'd12;
	localparam logic [3:0] S_E_ADR = 4'd13;
	localparam logic [3:0] S_E_OUT = 4'd14;

	logic [ID_BITS-1:0] id_mem  [CAPACITY];
	logic [PACK_W-1:0]  sc_mem  [CAPACITY];
	logic [SUM_W-1:0]   sum_mem [CAPACITY];
	logic [IDX_W-1:0]   ord_mem [CAPACITY];
	logic [SB_W-1:0]    sb_mem  [CAPACITY];

	logic [ID_BITS-1:0] id_rd;
	logic [PACK_W-1:0]  sc_rd;
	logic [SUM_W-1:0]   sum_rd;
	logic [IDX_W-1:0]   ord_rd;
	logic [SB_W-1:0]    sb_rd;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] slot_q;
	logic [SB_W-1:0]  key_q;
	cmd_t             cmd_q;
	logic             done_q;
	res_t             res_q;

	logic [IDX_W-1:0] slot_ra;
	logic [IDX_W-1:0] sb_ra;
	logic [IDX_W-1:0] cnt_idx;
	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] last_idx;
	logic             is_last;
	logic             full;
	logic [PACK_W-1:0] sc_new;
	logic [1:0]       st_first;

	logic             ord_we;
	logic [IDX_W-1:0] ord_wa;
	logic [IDX_W-1:0] ord_wd;
	logic             sb_we;
	logic [IDX_W-1:0] sb_wa;
	logic [SB_W-1:0]  sb_wd;
	logic             add_we;
	logic             mod_we;

	assign cnt_idx  = cnt_q[IDX_W-1:0];
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign last_idx = cnt_m1[IDX_W-1:0];
	assign is_last  = (i_q == last_idx);
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign pop      = (state_q == S_IDLE) && q_valid;

	always_comb begin
		sc_new = sc_rd;
		sc_new[{cmd_q.slot, 3'b000} +: SCORE_W] = cmd_q.nscore;
	end

	always_comb begin
		case (q_cmd.op)
			OP_ADD:  st_first = full ? ST_FULL : ST_OK;
			OP_MOD:  st_first = ST_NOTFOUND;
			default: st_first = ST_EMPTY;
		endcase
	end

	always_comb begin
		slot_ra = ord_rd;
		sb_ra   = i_q;
		case (state_q)
			S_E_ADR: slot_ra = sb_rd[SB_W-1 -: IDX_W];
			S_J_RD:  sb_ra = j_q;
			default: begin
			end
		endcase
	end

	always_comb begin
		add_we = pop && (q_cmd.op == OP_ADD) && !full;
		mod_we = (state_q == S_M_CMP) && (id_rd == cmd_q.id[ID_BITS-1:0]);
		ord_we = add_we;
		ord_wa = cnt_idx;
		ord_wd = cnt_idx;
		sb_we  = 1'b0;
		sb_wa  = i_q;
		sb_wd  = {slot_q, sum_rd};
		case (state_q)
			S_L_WR: sb_we = 1'b1;
			S_J_CMP: begin
				if (sb_rd[SUM_W-1:0] >= key_q[SUM_W-1:0]) begin
					ord_we = 1'b1;
					ord_wa = j_q + IDX_W'(1);
					ord_wd = sb_rd[SB_W-1 -: IDX_W];
					sb_we  = 1'b1;
					sb_wa  = j_q + IDX_W'(1);
					sb_wd  = sb_rd;
				end
			end
			S_PUT: begin
				ord_we = 1'b1;
				ord_wa = pos_q;
				ord_wd = key_q[SB_W-1 -: IDX_W];
				sb_we  = 1'b1;
				sb_wa  = pos_q;
				sb_wd  = key_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (add_we) begin
			id_mem[cnt_idx]  <= q_cmd.id[ID_BITS-1:0];
			sc_mem[cnt_idx]  <= q_cmd.scores;
			sum_mem[cnt_idx] <= packed_sum(q_cmd.scores);
		end else if (mod_we) begin
			sc_mem[slot_q]  <= sc_new;
			sum_mem[slot_q] <= packed_sum(sc_new);
		end
		if (ord_we) begin
			ord_mem[ord_wa] <= ord_wd;
		end
		if (sb_we) begin
			sb_mem[sb_wa] <= sb_wd;
		end
		id_rd  <= id_mem[slot_ra];
		sc_rd  <= sc_mem[slot_ra];
		sum_rd <= sum_mem[slot_ra];
		ord_rd <= ord_mem[i_q];
		sb_rd  <= sb_mem[sb_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (q_cmd.op)
							OP_ADD: begin
								done_q <= 1'b1;
								if (!full) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							OP_MOD: begin
								if (cnt_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_M_ORD;
								end
							end
							OP_READ: begin
								if (cnt_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_L_ORD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_M_ORD: state_q <= S_M_ID;
				S_M_ID:  state_q <= S_M_CMP;
				S_M_CMP: begin
					if (mod_we || is_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_M_ORD;
					end
				end
				S_L_ORD: state_q <= S_L_SUM;
				S_L_SUM: state_q <= S_L_WR;
				S_L_WR: begin
					if (!is_last) begin
						state_q <= S_L_ORD;
					end else if (cnt_q == CNT_W'(1)) begin
						state_q <= S_E_ORD;
					end else begin
						state_q <= S_K_RD;
					end
				end
				S_K_RD:  state_q <= S_K_LD;
				S_K_LD:  state_q <= S_J_RD;
				S_J_RD:  state_q <= S_J_CMP;
				S_J_CMP: begin
					if (sb_rd[SUM_W-1:0] >= key_q[SUM_W-1:0] && j_q != '0) begin
						state_q <= S_J_RD;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					state_q <= is_last ? S_E_ORD : S_K_RD;
				end
				S_E_ORD: state_q <= S_E_ADR;
				S_E_ADR: state_q <= S_E_OUT;
				S_E_OUT: begin
					done_q  <= 1'b1;
					state_q <= is_last ? S_IDLE : S_E_ORD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				i_q <= '0;
				if (pop) begin
					cmd_q <= q_cmd;
					res_q <= '{status: st_first, id: '0, scores: '0, total: '0,
						last: 1'b1};
				end
			end
			S_M_ID:  slot_q <= ord_rd;
			S_M_CMP: begin
				res_q.status <= mod_we ? ST_OK : ST_NOTFOUND;
				i_q          <= i_q + IDX_W'(1);
			end
			S_L_SUM: slot_q <= ord_rd;
			S_L_WR: begin
				if (!is_last) begin
					i_q <= i_q + IDX_W'(1);
				end else if (cnt_q == CNT_W'(1)) begin
					i_q <= '0;
				end else begin
					i_q <= IDX_W'(1);
				end
			end
			S_K_LD: begin
				key_q <= sb_rd;
				j_q   <= i_q - IDX_W'(1);
			end
			S_J_CMP: begin
				if (sb_rd[SUM_W-1:0] >= key_q[SUM_W-1:0]) begin
					if (j_q == '0) begin
						pos_q <= '0;
					end else begin
						j_q <= j_q - IDX_W'(1);
					end
				end else begin
					pos_q <= j_q + IDX_W'(1);
				end
			end
			S_PUT: begin
				i_q <= is_last ? '0 : i_q + IDX_W'(1);
			end
			S_E_OUT: begin
				res_q <= '{status: ST_OK, id: ID_W'(id_rd), scores: sc_rd, total: sum_rd,
					last: is_last};
				i_q   <= i_q + IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* hw/rtl/sorted_record_table.sv */
// Sorted record table: takes one command per start while busy is low and
// answers with results marked by done, one cycle each; the receiver cannot
// stall. Add and modify give one status result; modify searches the records
// in the stored order. A readout gives one result per record, the last one
// marked (a read of an empty table gives one status result): it copies the
// order list with each record's total into the sort buffer, insertion-sorts
// it there by total, then emits the records in that order. A two-deep command
// queue lets new commands be taken while the engine works; busy is high only
// while it is full.
module sorted_record_table import srt_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int ID_BITS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [63:0] record_id,
	input  logic [7:0]  first_score,
	input  logic [7:0]  second_score,
	input  logic [7:0]  third_score,
	input  logic [7:0]  fourth_score,
	input  logic [1:0]  score_slot,
	input  logic [7:0]  new_score,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] out_id,
	output logic [7:0]  out_score_one,
	output logic [7:0]  out_score_two,
	output logic [7:0]  out_score_three,
	output logic [7:0]  out_score_four,
	output logic [9:0]  score_total,
	output logic        last
);

	cmd_t cmd_in;
	cmd_t q_cmd;
	logic q_valid;
	logic pop;
	res_t res;

	assign cmd_in = '{op: op, id: record_id,
		scores: {fourth_score, third_score, second_score, first_score},
		slot: score_slot, nscore: new_score};

	srt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd_in  (cmd_in),
		.busy    (busy),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.pop     (pop)
	);

	srt_back #(
		.CAPACITY (CAPACITY),
		.ID_BITS  (ID_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.pop     (pop),
		.done    (done),
		.res     (res)
	);

	assign status          = res.status;
	assign out_id          = res.id;
	assign out_score_one   = res.scores[7:0];
	assign out_score_two   = res.scores[15:8];
	assign out_score_three = res.scores[23:16];
	assign out_score_four  = res.scores[31:24];
	assign score_total     = res.total;
	assign last            = res.last;

endmodule

/* hw/rtl/srt_checker.sv */
// port-level checks of the sorted record table and their binding
`include "assert_macros.svh"

module srt_checker import srt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [63:0] out_id,
	input logic [9:0]  score_total,
	input logic        last
);

	`SRT_ASSERT(a_err_single, clk, arst_n, !(done && status != ST_OK) || last, "status result not last")
	`SRT_ASSERT(a_err_zero, clk, arst_n, !(done && status != ST_OK) || (out_id == '0 && score_total == '0), "status result carries data")
	`SRT_ASSERT_NEXT(a_gap, clk, arst_n, done && !last, !done, "readout results back to back")
	`SRT_ASSERT(a_busy_rise, clk, arst_n, !$rose(busy) || $past(start), "busy rose without a transaction")

endmodule

bind sorted_record_table srt_checker u_srt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.out_id      (out_id),
	.score_total (score_total),
	.last        (last)
);

/* bench/testbench.sv */
// self-checking bench for the sorted record table: directed and random transactions
`timescale 1ns / 1ps

module testbench;
	import srt_pkg::*;

	localparam int CAP        = 32;
	localparam int TIME_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = OP_ADD;
	logic [63:0] record_id = '0;
	logic [7:0]  first_score = '0, second_score = '0, third_score = '0, fourth_score = '0;
	logic [1:0]  score_slot = '0;
	logic [7:0]  new_score = '0;
	logic        done;
	logic [1:0]  status;
	logic [63:0] out_id;
	logic [7:0]  out_score_one, out_score_two, out_score_three, out_score_four;
	logic [9:0]  score_total;
	logic        last;

	sorted_record_table i_dut (.*);

	always #1 clk = ~clk;

	// table shadow
	logic [63:0]       tbl_id [CAP];
	logic [PACK_W-1:0] tbl_scores [CAP];
	logic [SUM_W-1:0]  tbl_sum [CAP];
	int                tbl_order [CAP];
	int                tbl_count;

	res_t result_queue [$];
	int   error_count = 0;
	int   cycle_count = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	function automatic logic [SUM_W-1:0] score_sum(input logic [PACK_W-1:0] p);
		return SUM_W'(p[7:0]) + SUM_W'(p[15:8]) + SUM_W'(p[23:16]) + SUM_W'(p[31:24]);
	endfunction

	function automatic res_t status_result(input logic [1:0] st);
		res_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_table(input cmd_t c);
		int sorted [CAP];
		int placed, p, cur;
		res_t r;
		logic [4:0] sh;
		logic done_mod;
		case (c.op)
			OP_ADD: begin
				if (tbl_count >= CAP) begin
					result_queue.push_back(status_result(ST_FULL));
				end else begin
					tbl_id[tbl_count] = c.id;
					tbl_scores[tbl_count] = c.scores;
					tbl_sum[tbl_count] = score_sum(c.scores);
					tbl_order[tbl_count] = tbl_count;
					tbl_count++;
					result_queue.push_back(status_result(ST_OK));
				end
			end
			OP_MOD: begin
				done_mod = 1'b0;
				sh = {c.slot, 3'b000};
				for (int i = 0; i < tbl_count && !done_mod; i++) begin
					cur = tbl_order[i];
					if (tbl_id[cur] == c.id) begin
						tbl_scores[cur] = (tbl_scores[cur] & ~(32'hFF << sh)) |
							(32'(c.nscore) << sh);
						tbl_sum[cur] = score_sum(tbl_scores[cur]);
						done_mod = 1'b1;
					end
				end
				result_queue.push_back(status_result(done_mod ? ST_OK : ST_NOTFOUND));
			end
			OP_READ: begin
				if (tbl_count == 0) begin
					result_queue.push_back(status_result(ST_EMPTY));
				end else begin
					placed = 0;
					for (int i = 0; i < tbl_count; i++) begin
						cur = tbl_order[i];
						p = 0;
						while (p < placed && tbl_sum[sorted[p]] < tbl_sum[cur]) p++;
						for (int k = placed; k > p; k--) sorted[k] = sorted[k-1];
						sorted[p] = cur;
						placed++;
					end
					for (int i = 0; i < tbl_count; i++) begin
						tbl_order[i] = sorted[i];
						r.status = ST_OK;
						r.id = tbl_id[sorted[i]];
						r.scores = tbl_scores[sorted[i]];
						r.total = tbl_sum[sorted[i]];
						r.last = (i == tbl_count - 1);
						result_queue.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_command(input cmd_t c);
		start <= 1'b1;
		op <= c.op;
		record_id <= c.id;
		first_score <= c.scores[7:0];
		second_score <= c.scores[15:8];
		third_score <= c.scores[23:16];
		fourth_score <= c.scores[31:24];
		score_slot <= c.slot;
		new_score <= c.nscore;
		do @(posedge clk); while (busy);
		predict_table(c);
		start <= 1'b0;
		idle_gap();
	endtask

	function automatic cmd_t make_cmd(input logic [1:0] o, input logic [63:0] id,
		input logic [31:0] sc, input logic [1:0] sl, input logic [7:0] ns);
		cmd_t c;
		c.op = o; c.id = id; c.scores = sc; c.slot = sl; c.nscore = ns;
		return c;
	endfunction

	function automatic logic [63:0] rand_id();
		return {$urandom(), $urandom()};
	endfunction

	// small id pool so modifies hit and duplicates occur
	logic [63:0] id_pool [8];

	function automatic logic [31:0] rand_scores();
		logic [31:0] s;
		case ($urandom_range(0, 3))
			0: s = $urandom();
			1: s = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
			2: s = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: s = $urandom() | 32'h8080_8080;
		endcase
		return s;
	endfunction

	task automatic test_directed();
		send_command(make_cmd(OP_READ, '0, '0, 2'd0, 8'h00));
		send_command(make_cmd(OP_MOD, 64'h5, '0, 2'd0, 8'h10));
		send_command(make_cmd(OP_NONE, '1, '1, 2'd3, 8'hFF));
		send_command(make_cmd(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 2'd0, 8'h00));
		send_command(make_cmd(OP_ADD, 64'h0, 32'h0, 2'd0, 8'h00));
		send_command(make_cmd(OP_ADD, 64'h7, 32'h0101_0101, 2'd0, 8'h00));
		send_command(make_cmd(OP_ADD, 64'h7, 32'h0004_0000, 2'd0, 8'h00));
		send_command(make_cmd(OP_READ, '0, '0, 2'd0, 8'h00));
		send_command(make_cmd(OP_MOD, 64'h7, '0, 2'd3, 8'hFF));
		send_command(make_cmd(OP_MOD, 64'h0, '0, 2'd1, 8'h80));
		send_command(make_cmd(OP_MOD, 64'hFFFF_FFFF_FFFF_FFFF, '0, 2'd2, 8'h00));
		send_command(make_cmd(OP_MOD, 64'h1234, '0, 2'd0, 8'h01));
		send_command(make_cmd(OP_READ, '0, '0, 2'd0, 8'h00));
		for (int i = 0; i < 30; i++)
			send_command(make_cmd(OP_ADD, 64'(i % 3), 32'h0202_0202, 2'd0, 8'h00));
		send_command(make_cmd(OP_ADD, 64'h99, 32'h1, 2'd0, 8'h00));
		send_command(make_cmd(OP_READ, '0, '0, 2'd0, 8'h00));
	endtask

	task automatic test_random();
		logic [1:0] o;
		int r;
		for (int i = 0; i < 8; i++) id_pool[i] = rand_id();
		for (int i = 0; i < 250; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) o = OP_ADD;
			else if (r < 80) o = OP_MOD;
			else if (r < 92) o = OP_READ;
			else o = OP_NONE;
			send_command(make_cmd(o,
				$urandom_range(0, 4) == 0 ? rand_id() : id_pool[$urandom_range(0, 7)],
				rand_scores(), 2'($urandom_range(0, 3)), 8'($urandom())));
		end
		send_command(make_cmd(OP_READ, '0, '0, 2'd0, 8'h00));
	endtask

	task automatic test_refill();
		// fresh table only via reset is not allowed, so keep exercising full table
		for (int i = 0; i < 4; i++)
			send_command(make_cmd(OP_ADD, rand_id(), rand_scores(), 2'd0, 8'h00));
		send_command(make_cmd(OP_MOD, tbl_id[tbl_order[0]], '0, 2'd0, 8'hFF));
		send_command(make_cmd(OP_READ, '0, '0, 2'd0, 8'h00));
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (result_queue.size() == 0) begin
				report_mismatch("result with no transaction pending");
			end else begin
				e = result_queue.pop_front();
				if (status !== e.status) report_mismatch("status");
				if (out_id !== e.id) report_mismatch("out_id");
				if (out_score_one !== e.scores[7:0]) report_mismatch("out_score_one");
				if (out_score_two !== e.scores[15:8]) report_mismatch("out_score_two");
				if (out_score_three !== e.scores[23:16]) report_mismatch("out_score_three");
				if (out_score_four !== e.scores[31:24]) report_mismatch("out_score_four");
				if (score_total !== e.total) report_mismatch("score_total");
				if (last !== e.last) report_mismatch("last");
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIME_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		tbl_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_refill();
		while (result_queue.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
